// ----- src/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT_NORST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/bcr_pkg.sv -----
// ----------------------------------------------------------------------------
// bcr_pkg
// Types and constants shared by the circle rasterizer modules.
// ----------------------------------------------------------------------------
package bcr_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int CIN_W       = 10;
    localparam int RAD_W       = 9;
    localparam int PIX_W       = 12;
    localparam int OX_W        = 10;
    localparam int OY_W        = 11;
    localparam int DEC_W       = 14;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    localparam logic [DEC_W-1:0] DEC_INIT  = 14'd3;
    localparam logic [DEC_W-1:0] STEP_DIAG = 14'd10;
    localparam logic [DEC_W-1:0] STEP_AXIS = 14'd6;

    typedef struct packed {
        logic             mode;
        logic [CIN_W-1:0] centre_x;
        logic [CIN_W-1:0] centre_y;
        logic [RAD_W-1:0] radius;
    } t_in_item;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    group_last;
        logic                    circle_done;
    } t_out_item;

    // one symmetric group as handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] cx;
        logic [PIX_W-1:0] cy;
        logic [OX_W-1:0]  x;
        logic [OY_W-1:0]  y;
        logic             done;
    } t_group;

endpackage

// ----- src/bcr_front.sv -----
// ----------------------------------------------------------------------------
// bcr_front
// Takes start/step requests, advances the midpoint state, pushes one group
// descriptor per start or active step.
// ----------------------------------------------------------------------------
module bcr_front import bcr_pkg::*; #(
    parameter int COORD_W = COORD_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_group   o_group
);

    logic [OX_W-1:0]    r_offset_x, n_offset_x;
    logic [OY_W-1:0]    r_offset_y, n_offset_y;
    logic [DEC_W-1:0]   r_decision, n_decision;
    logic [COORD_W-1:0] r_centre_x, n_centre_x;
    logic [COORD_W-1:0] r_centre_y, n_centre_y;
    logic               r_active, n_active;

    logic                       accept;
    logic                       is_start;
    logic [COORD_W+CIN_W-1:0]   cin_x_ext, cin_y_ext;
    logic [COORD_W+PIX_W-1:0]   cpix_x_ext, cpix_y_ext;
    logic [OX_W-1:0]            x_inc;
    logic [OY_W-1:0]            y_dec, y_step;
    logic [DEC_W-1:0]           x14, y14, d_diag, d_axis, r14;
    logic                       dec_pos;
    logic                       step_done;
    logic                       group_done;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_start   = (i_in_data.mode == MODE_START);

    // centre resized to the stored width
    assign cin_x_ext = {{COORD_W{1'b0}}, i_in_data.centre_x};
    assign cin_y_ext = {{COORD_W{1'b0}}, i_in_data.centre_y};

    // step arithmetic
    assign x_inc   = r_offset_x + 1'b1;
    assign y_dec   = r_offset_y - 1'b1;
    assign dec_pos = !r_decision[DEC_W-1] && (r_decision != '0);
    assign y_step  = dec_pos ? y_dec : r_offset_y;
    assign x14     = {{(DEC_W-OX_W){1'b0}}, x_inc};
    assign y14     = {{(DEC_W-OY_W){y_dec[OY_W-1]}}, y_dec};
    assign d_diag  = r_decision + ((x14 - y14) << 2) + STEP_DIAG;
    assign d_axis  = r_decision + (x14 << 2) + STEP_AXIS;
    assign r14     = {{(DEC_W-RAD_W){1'b0}}, i_in_data.radius};
    assign step_done = $signed({y_step[OY_W-1], y_step})
                     < $signed({{(PIX_W-OX_W){1'b0}}, x_inc});

    // next state
    always_comb begin
        n_offset_x = r_offset_x;
        n_offset_y = r_offset_y;
        n_decision = r_decision;
        n_centre_x = r_centre_x;
        n_centre_y = r_centre_y;
        n_active   = r_active;
        o_push     = 1'b0;
        group_done = 1'b0;
        if (accept) begin
            if (is_start) begin
                n_centre_x = cin_x_ext[COORD_W-1:0];
                n_centre_y = cin_y_ext[COORD_W-1:0];
                n_offset_x = '0;
                n_offset_y = {{(OY_W-RAD_W){1'b0}}, i_in_data.radius};
                n_decision = DEC_INIT - (r14 << 1);
                n_active   = 1'b1;
                o_push     = 1'b1;
            end else if (r_active) begin
                n_offset_x = x_inc;
                n_offset_y = y_step;
                n_decision = dec_pos ? d_diag : d_axis;
                n_active   = !step_done;
                o_push     = 1'b1;
                group_done = step_done;
            end
        end
    end

    // group descriptor from the updated state
    assign cpix_x_ext   = {{PIX_W{1'b0}}, n_centre_x};
    assign cpix_y_ext   = {{PIX_W{1'b0}}, n_centre_y};
    assign o_group.cx   = cpix_x_ext[PIX_W-1:0];
    assign o_group.cy   = cpix_y_ext[PIX_W-1:0];
    assign o_group.x    = n_offset_x;
    assign o_group.y    = n_offset_y;
    assign o_group.done = group_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_decision <= '0;
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_active   <= 1'b0;
        end else begin
            r_offset_x <= n_offset_x;
            r_offset_y <= n_offset_y;
            r_decision <= n_decision;
            r_centre_x <= n_centre_x;
            r_centre_y <= n_centre_y;
            r_active   <= n_active;
        end
    end

endmodule

// ----- src/bcr_queue.sv -----
// ----------------------------------------------------------------------------
// bcr_queue
// Small FIFO of group descriptors between front and back.
// ----------------------------------------------------------------------------
module bcr_queue import bcr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_group o_group
);

    t_group            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QUEUE_DEPTH[QPTR_W:0]);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_group = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- src/bcr_back.sv -----
// ----------------------------------------------------------------------------
// bcr_back
// Walks the eight symmetric pixels of each queued group into the output
// register, one pixel per cycle while a group waits and no stall holds.
// ----------------------------------------------------------------------------
module bcr_back import bcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_group    i_group,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_data;

    logic             load;
    logic [PIX_W-1:0] x12, y12, kx, ky, px, py;

    assign load = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_pop = load && (r_idx == IDX_LAST);

    // pixel select: bit 2 swaps the axes, bits 0 and 1 negate
    assign x12 = {{(PIX_W-OX_W){1'b0}}, i_group.x};
    assign y12 = {{(PIX_W-OY_W){i_group.y[OY_W-1]}}, i_group.y};
    assign kx  = r_idx[2] ? y12 : x12;
    assign ky  = r_idx[2] ? x12 : y12;
    assign px  = r_idx[0] ? i_group.cx - kx : i_group.cx + kx;
    assign py  = r_idx[1] ? i_group.cy - ky : i_group.cy + ky;

    // control next values
    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_idx       = r_idx + 1'b1;
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data.pixel_x     <= $signed(px);
            r_out_data.pixel_y     <= $signed(py);
            r_out_data.group_last  <= (r_idx == IDX_LAST);
            r_out_data.circle_done <= i_group.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- src/bresenham_circle_rasterizer.sv -----
// ----------------------------------------------------------------------------
// bresenham_circle_rasterizer
// Midpoint circle generator giving eight symmetric pixels per point.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): a start request
// (mode 0) loads centre and radius and yields the first group; a step
// request (mode 1) advances one point along the octant and yields its group.
// A step while no circle is active is taken and yields nothing.
// Output channel (o_out_valid / i_out_stall / o_out_data): one pixel per
// transfer, eight per group, group_last on the eighth, circle_done on all
// eight of the group that finishes the circle.
// The single pixel output port limits how fast start and active step
// requests can be served; a step while idle yields no pixels.
// With the back idle, the first pixel of a group passes through the queue
// and then the output register before it is valid.
// The front updates the circle state on each accepted request, and a
// two-group queue lets it take requests while the back is still emitting.
// When the receiver stalls, the current pixel holds; once the queue fills,
// o_in_stall rises. Reset clears the circle state to idle, empties the
// queue and drops o_out_valid.
// ----------------------------------------------------------------------------
module bresenham_circle_rasterizer import bcr_pkg::*; #(
    parameter int COORD_W = COORD_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic   q_push, q_pop, q_full, q_empty;
    t_group front_group, back_group;

    bcr_front #(
        .COORD_W (COORD_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_group    (front_group)
    );

    bcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (front_group),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_group (back_group)
    );

    bcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_group     (back_group),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- src/bcr_checker.sv -----
// ----------------------------------------------------------------------------
// bcr_checker
// Port-level checks on the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcr_checker import bcr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled pixel stays valid
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a stalled pixel keeps its payload
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // reset drops the output
    `ASSERT_NEXT_NORST(a_rst_out, i_clk, !i_rst_n, !o_out_valid)

    // reset empties the queue, so requests are taken right after
    `ASSERT_NEXT_NORST(a_rst_in, i_clk, !i_rst_n, !o_in_stall)

endmodule

bind bresenham_circle_rasterizer bcr_checker u_bcr_checker (.*);

// ----- dv/tb_bresenham_circle_rasterizer.sv -----
// ----------------------------------------------------------------------------
// tb_bresenham_circle_rasterizer
// Self-checking bench for the midpoint circle rasterizer. A behavioral copy
// of the circle walk predicts the eight pixels of every start and active step
// request. A checker compares each pixel taken from the output channel, field
// by field, against the oldest prediction. Directed requests come first, then
// random circles under three idling schemes on the two channels.
// ----------------------------------------------------------------------------
module tb_bresenham_circle_rasterizer;
    import bcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    bresenham_circle_rasterizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // predicted circle state
    logic        [OX_W-1:0]  walk_x;
    logic signed [OY_W-1:0]  walk_y;
    logic signed [DEC_W-1:0] walk_d;
    logic        [CIN_W-1:0] walk_cx;
    logic        [CIN_W-1:0] walk_cy;
    bit                      circle_active;

    t_out_item expected_pixels[$];
    t_out_item want_pixel;
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // queue the eight symmetric pixels of the current point
    function automatic void queue_octants(bit done);
        int        cx, cy, x, y;
        int        px[8];
        int        py[8];
        t_out_item pix;
        cx = walk_cx;
        cy = walk_cy;
        x  = walk_x;
        y  = walk_y;
        px = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
        py = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
        for (int k = 0; k < 8; k++) begin
            pix.pixel_x     = PIX_W'(px[k]);
            pix.pixel_y     = PIX_W'(py[k]);
            pix.group_last  = (k == IDX_LAST);
            pix.circle_done = done;
            expected_pixels.push_back(pix);
        end
    endfunction

    // advance the predicted walk by one accepted request
    function automatic void rasterize(t_in_item req);
        int x, y, d;
        bit done;
        if (req.mode == MODE_START) begin
            walk_cx       = req.centre_x;
            walk_cy       = req.centre_y;
            walk_x        = '0;
            walk_y        = OY_W'(int'(req.radius));
            walk_d        = DEC_W'(3 - 2 * int'(req.radius));
            circle_active = 1'b1;
            queue_octants(1'b0);
        end else if (circle_active) begin
            x = (int'(walk_x) + 1) & ((1 << OX_W) - 1);
            y = walk_y;
            d = walk_d;
            if (d > 0) begin
                walk_y = OY_W'(y - 1);
                y      = walk_y;
                walk_d = DEC_W'(d + 4 * (x - y) + 10);
            end else begin
                walk_d = DEC_W'(d + 4 * x + 6);
            end
            walk_x = OX_W'(x);
            done   = (y < x);
            if (done) begin
                circle_active = 1'b0;
            end
            queue_octants(done);
        end
    endfunction

    function automatic t_in_item make_req(logic mode, int cx, int cy, int r);
        t_in_item req;
        req.mode     = mode;
        req.centre_x = CIN_W'(cx);
        req.centre_y = CIN_W'(cy);
        req.radius   = RAD_W'(r);
        return req;
    endfunction

    // step with junk in the unused fields
    function automatic t_in_item step_req();
        return make_req(MODE_STEP, $urandom, $urandom, $urandom);
    endfunction

    // send one request; entered and left just after a falling edge
    task automatic push_request(t_in_item req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            i_in_data  = make_req(1'($urandom), $urandom, $urandom, $urandom);
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        rasterize(req);
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // compare each taken pixel with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel (%0d, %0d)",
                    o_out_data.pixel_x, o_out_data.pixel_y));
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (o_out_data.pixel_x !== want_pixel.pixel_x) begin
                    report_mismatch($sformatf("pixel_x got %0d want %0d",
                        o_out_data.pixel_x, want_pixel.pixel_x));
                end
                if (o_out_data.pixel_y !== want_pixel.pixel_y) begin
                    report_mismatch($sformatf("pixel_y got %0d want %0d",
                        o_out_data.pixel_y, want_pixel.pixel_y));
                end
                if (o_out_data.group_last !== want_pixel.group_last) begin
                    report_mismatch($sformatf("group_last got %b want %b",
                        o_out_data.group_last, want_pixel.group_last));
                end
                if (o_out_data.circle_done !== want_pixel.circle_done) begin
                    report_mismatch($sformatf("circle_done got %b want %b",
                        o_out_data.circle_done, want_pixel.circle_done));
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // corner radii, centres at the edges, idle steps and abandoned circles
    task automatic test_directed_corners();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // radius zero: start at the centre, first step finishes
        push_request(make_req(MODE_START, 0, 0, 0));
        push_request(step_req());
        // step with nothing active gives no pixels
        push_request(make_req(MODE_STEP, 1023, 1023, 511));
        // largest radius at the far corner, abandoned after a few steps
        push_request(make_req(MODE_START, 1023, 1023, 511));
        repeat (3) push_request(step_req());
        // restart while active, radius one finishes on one diagonal step
        push_request(make_req(MODE_START, 512, 0, 1));
        push_request(step_req());
        push_request(make_req(MODE_STEP, 0, 0, 0));
        push_request(make_req(MODE_START, 0, 1023, 2));
        while (circle_active) push_request(step_req());
        push_request(make_req(MODE_START, 1023, 0, 3));
        while (circle_active) push_request(step_req());
        push_request(make_req(MODE_START, 0, 0, 511));
        push_request(step_req());
        push_request(make_req(MODE_START, 341, 682, 256));
        push_request(step_req());
    endtask

    // mostly complete circles, some restarts and stray steps
    task automatic test_random_circles(int idle_pct, int stall_pct, int n_items);
        int roll;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            if ((circle_active && roll < 92) || (!circle_active && roll >= 85)) begin
                push_request(step_req());
            end else if ($urandom_range(0, 99) < 85) begin
                push_request(make_req(MODE_START, $urandom, $urandom,
                    $urandom_range(0, 12)));
            end else begin
                push_request(make_req(MODE_START, $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        walk_x        = '0;
        walk_y        = '0;
        walk_d        = '0;
        walk_cx       = '0;
        walk_cy       = '0;
        circle_active = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_random_circles(13, 67, 60);
        test_random_circles(67, 13, 60);
        test_random_circles(0, 0, 60);
        i_in_valid = 1'b0;

        // drain, then allow for any late extra pixels
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
